// ===== rtl/lod_select_screen_coverage_defines.svh =====
// Assertion macros used by the checked RTL file
`ifndef LOD_SELECT_SCREEN_COVERAGE_DEFINES_SVH
`define LOD_SELECT_SCREEN_COVERAGE_DEFINES_SVH
`ifndef ASSERT_OFF
`define LSC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define LSC_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");
`else
`define LSC_ASSERT(lbl, prop)
`define LSC_ASSERT_NR(lbl, prop)
`endif
`endif

// ===== rtl/lsc_pkg.sv =====
package lsc_pkg;
  localparam int FRAC_BITS = 16;
  localparam int EPS_Q = ((1 << FRAC_BITS) + 500) / 1000;
  localparam logic [63:0] EPS_DEN = 64'(EPS_Q) << FRAC_BITS;
  localparam int SQRT_CELLS = 32;
  localparam int DIV_CELLS = 32 + 2 * FRAC_BITS;
  localparam int DIV_IDX_W = $clog2(DIV_CELLS);
  localparam int SQRT_IDX_W = $clog2(SQRT_CELLS);

  // register indexes
  localparam logic [3:0] REG_CAM_X = 4'd0;
  localparam logic [3:0] REG_CAM_Y = 4'd1;
  localparam logic [3:0] REG_CAM_Z = 4'd2;
  localparam logic [3:0] REG_TAN   = 4'd3;
  localparam logic [3:0] REG_TH4   = 4'd4;
  localparam logic [3:0] REG_TH3   = 4'd5;
  localparam logic [3:0] REG_TH2   = 4'd6;
  localparam logic [3:0] REG_TH1   = 4'd7;

  // detail levels
  localparam logic [2:0] LVL_0 = 3'd0;
  localparam logic [2:0] LVL_1 = 3'd1;
  localparam logic [2:0] LVL_2 = 3'd2;
  localparam logic [2:0] LVL_3 = 3'd3;
  localparam logic [2:0] LVL_4 = 3'd4;

  // data riding along the square root chain
  typedef struct packed {
    logic [31:0] radius;
    logic [31:0] prev;
    logic [2:0]  cur;
    logic        be;
    logic        over;
  } lsc_side_t;

  // data riding along the divider chain
  typedef struct packed {
    logic [31:0] radius;
    logic [31:0] prev;
    logic [31:0] dlen;
    logic [2:0]  cur;
    logic        be;
  } lsc_dside_t;
endpackage

// ===== rtl/lsc_if.sv =====
interface lsc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] radius;
  logic [31:0] prev_distance;
  logic [2:0]  current_level;
  logic        batch_end_in;
  modport source (output valid, pos_x, pos_y, pos_z, radius, prev_distance,
                  current_level, batch_end_in, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, radius, prev_distance,
                current_level, batch_end_in, output ready);
endinterface

interface lsc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  selected_level;
  logic [31:0] distance;
  logic [31:0] coverage;
  logic        batch_end_out;
  modport source (output valid, selected_level, distance, coverage, batch_end_out,
                  input ready);
  modport sink (input valid, selected_level, distance, coverage, batch_end_out,
                output ready);
endinterface

interface lsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/lsc_sqrt_cell.sv =====
// One restoring square root step; idx_i selects the bit pair handled here
module lsc_sqrt_cell import lsc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic [SQRT_IDX_W-1:0] idx_i,
  input  logic                  valid_i,
  input  logic [63:0]           v_i,
  input  logic [63:0]           res_i,
  input  lsc_side_t             side_i,
  output logic                  valid_o,
  output logic [63:0]           v_o,
  output logic [63:0]           res_o,
  output lsc_side_t             side_o
);
  logic [63:0] bit_w, trial, v_d, res_d;
  logic        valid_q;
  logic [63:0] v_q, res_q;
  lsc_side_t   side_q;

  always_comb begin
    bit_w = 64'd1 << {idx_i, 1'b0};
    trial = res_i + bit_w;
    if (v_i >= trial) begin
      v_d   = v_i - trial;
      res_d = (res_i >> 1) + bit_w;
    end else begin
      v_d   = v_i;
      res_d = res_i >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q    <= v_d;
      res_q  <= res_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign v_o     = v_q;
  assign res_o   = res_q;
  assign side_o  = side_q;
endmodule

// ===== rtl/lsc_div_cell.sv =====
// One restoring division step; high steps only flag saturation
module lsc_div_cell import lsc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [DIV_IDX_W-1:0] idx_i,
  input  logic                 valid_i,
  input  logic [63:0]          rem_i,
  input  logic [63:0]          den_i,
  input  logic [31:0]          q_i,
  input  logic                 sat_i,
  input  lsc_dside_t           side_i,
  output logic                 valid_o,
  output logic [63:0]          rem_o,
  output logic [63:0]          den_o,
  output logic [31:0]          q_o,
  output logic                 sat_o,
  output lsc_dside_t           side_o
);
  localparam int LOW = 2 * FRAC_BITS;

  logic        num_bit, take;
  logic [64:0] shifted;
  logic [63:0] rem_d;
  logic [31:0] q_d;
  logic        sat_d;
  logic        valid_q, sat_q;
  logic [63:0] rem_q, den_q;
  logic [31:0] q_q;
  lsc_dside_t  side_q;

  always_comb begin
    num_bit = 1'b0;
    if (32'(idx_i) >= LOW) begin
      num_bit = side_i.radius[5'(32'(idx_i) - LOW)];
    end
    shifted = {rem_i, num_bit};
    take    = shifted >= {1'b0, den_i};
    rem_d   = take ? 64'(shifted - {1'b0, den_i}) : shifted[63:0];
    // quotient bits at or above bit 32 mean the result saturates
    if (32'(idx_i) >= 32) begin
      q_d   = q_i;
      sat_d = sat_i | take;
    end else begin
      q_d   = {q_i[30:0], take};
      sat_d = sat_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      den_q  <= den_i;
      q_q    <= q_d;
      sat_q  <= sat_d;
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign den_o   = den_q;
  assign q_o     = q_q;
  assign sat_o   = sat_q;
  assign side_o  = side_q;
endmodule

// ===== rtl/lod_select_screen_coverage.sv =====
// Pipeline stages from input transaction to result:
// offset, square, sum, 32 square root cells, multiply, epsilon add,
// 64 divider cells and the output register.
// Throughput: one item per cycle; every stage advances together and holds
// while the output register waits on ready.
// Reset: rst_ni clears all valid bits and loads the register defaults.
module lod_select_screen_coverage import lsc_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  lsc_in_if.sink  in_i,
  lsc_out_if.source out_o,
  lsc_cfg_if.sink cfg_i
);
`include "lod_select_screen_coverage_defines.svh"

  logic [31:0] cam_x_q, cam_y_q, cam_z_q, tan_q;
  logic [15:0] th4_q, th3_q, th2_q, th1_q;
  logic        en;

  // configuration registers
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      cam_z_q <= '0;
      tan_q   <= 32'd65536;
      th4_q   <= 16'd655;
      th3_q   <= 16'd3277;
      th2_q   <= 16'd9830;
      th1_q   <= 16'd22938;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_CAM_X: cam_x_q <= cfg_i.data;
        REG_CAM_Y: cam_y_q <= cfg_i.data;
        REG_CAM_Z: cam_z_q <= cfg_i.data;
        REG_TAN:   tan_q   <= cfg_i.data;
        REG_TH4:   th4_q   <= cfg_i.data[15:0];
        REG_TH3:   th3_q   <= cfg_i.data[15:0];
        REG_TH2:   th2_q   <= cfg_i.data[15:0];
        REG_TH1:   th1_q   <= cfg_i.data[15:0];
        default: ;
      endcase
    end
  end

  // global advance: stall only while the result waits
  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;

  // stage 0: offset magnitudes
  logic [32:0] dx, dy, dz;
  logic [31:0] mx_q, my_q, mz_q;
  logic        v0_q, v1_q, v2_q;
  lsc_side_t   s0_q, s1_q, s2_q, s2_d, side_in;

  assign dx = {in_i.pos_x[31], in_i.pos_x} - {cam_x_q[31], cam_x_q};
  assign dy = {in_i.pos_y[31], in_i.pos_y} - {cam_y_q[31], cam_y_q};
  assign dz = {in_i.pos_z[31], in_i.pos_z} - {cam_z_q[31], cam_z_q};
  always_comb begin
    side_in.radius = in_i.radius;
    side_in.prev   = in_i.prev_distance;
    side_in.cur    = in_i.current_level;
    side_in.be     = in_i.batch_end_in;
    side_in.over   = 1'b0;
  end

  // stage 1 squares, stage 2 sum with overflow
  logic [63:0] sqx_q, sqy_q, sqz_q, sum_q;
  logic [65:0] sum3;
  assign sum3 = {2'b0, sqx_q} + {2'b0, sqy_q} + {2'b0, sqz_q};

  always_comb begin
    s2_d      = s1_q;
    s2_d.over = sum3[65:64] != 2'b00;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_i.valid;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q  <= dx[32] ? 32'(-dx) : dx[31:0];
      my_q  <= dy[32] ? 32'(-dy) : dy[31:0];
      mz_q  <= dz[32] ? 32'(-dz) : dz[31:0];
      s0_q  <= side_in;
      sqx_q <= mx_q * mx_q;
      sqy_q <= my_q * my_q;
      sqz_q <= mz_q * mz_q;
      s1_q  <= s0_q;
      sum_q <= sum3[63:0];
      s2_q  <= s2_d;
    end
  end

  // square root chain
  logic        sv  [SQRT_CELLS+1];
  logic [63:0] svv [SQRT_CELLS+1];
  logic [63:0] sres[SQRT_CELLS+1];
  lsc_side_t   sside[SQRT_CELLS+1];

  assign sv[0]    = v2_q;
  assign svv[0]   = sum_q;
  assign sres[0]  = '0;
  assign sside[0] = s2_q;

  for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
    lsc_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .idx_i   (SQRT_IDX_W'(SQRT_CELLS - 1 - k)),
      .valid_i (sv[k]),
      .v_i     (svv[k]),
      .res_i   (sres[k]),
      .side_i  (sside[k]),
      .valid_o (sv[k+1]),
      .v_o     (svv[k+1]),
      .res_o   (sres[k+1]),
      .side_o  (sside[k+1])
    );
  end

  // multiply by the view tangent, then add epsilon with saturation
  logic [31:0] dlen;
  logic [63:0] prod_q, den_q;
  logic [64:0] den_sum;
  logic        vm_q, va_q;
  lsc_dside_t  dm_q, da_q, dside_in;

  assign dlen = sside[SQRT_CELLS].over ? 32'hFFFF_FFFF : sres[SQRT_CELLS][31:0];
  always_comb begin
    dside_in.radius = sside[SQRT_CELLS].radius;
    dside_in.prev   = sside[SQRT_CELLS].prev;
    dside_in.dlen   = dlen;
    dside_in.cur    = sside[SQRT_CELLS].cur;
    dside_in.be     = sside[SQRT_CELLS].be;
  end
  assign den_sum = {1'b0, prod_q} + {1'b0, EPS_DEN};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
      va_q <= 1'b0;
    end else if (en) begin
      vm_q <= sv[SQRT_CELLS];
      va_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= dlen * tan_q;
      dm_q   <= dside_in;
      den_q  <= den_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : den_sum[63:0];
      da_q   <= dm_q;
    end
  end

  // divider chain
  logic        dv   [DIV_CELLS+1];
  logic [63:0] drem [DIV_CELLS+1];
  logic [63:0] dden [DIV_CELLS+1];
  logic [31:0] dq   [DIV_CELLS+1];
  logic        dsat [DIV_CELLS+1];
  lsc_dside_t  dside[DIV_CELLS+1];

  assign dv[0]    = va_q;
  assign drem[0]  = '0;
  assign dden[0]  = den_q;
  assign dq[0]    = '0;
  assign dsat[0]  = 1'b0;
  assign dside[0] = da_q;

  for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
    lsc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .idx_i   (DIV_IDX_W'(DIV_CELLS - 1 - k)),
      .valid_i (dv[k]),
      .rem_i   (drem[k]),
      .den_i   (dden[k]),
      .q_i     (dq[k]),
      .sat_i   (dsat[k]),
      .side_i  (dside[k]),
      .valid_o (dv[k+1]),
      .rem_o   (drem[k+1]),
      .den_o   (dden[k+1]),
      .q_o     (dq[k+1]),
      .sat_o   (dsat[k+1]),
      .side_o  (dside[k+1])
    );
  end

  // level selection with hysteresis
  lsc_dside_t  fs;
  logic [31:0] cov, change;
  logic [63:0] cs;
  logic [35:0] change10;
  logic [2:0]  level;

  assign fs       = dside[DIV_CELLS];
  assign cov      = dsat[DIV_CELLS] ? 32'hFFFF_FFFF : dq[DIV_CELLS];
  assign cs       = {16'b0, cov, 16'b0};
  assign change   = (fs.dlen > fs.prev) ? fs.dlen - fs.prev : fs.prev - fs.dlen;
  assign change10 = {4'b0, change} * 36'd10;

  always_comb begin
    if (cs < (64'(th4_q) << FRAC_BITS)) begin
      level = LVL_4;
    end else if (cs < (64'(th3_q) << FRAC_BITS)) begin
      level = LVL_3;
    end else if (cs < (64'(th2_q) << FRAC_BITS)) begin
      level = LVL_2;
    end else if (cs < (64'(th1_q) << FRAC_BITS)) begin
      level = LVL_1;
    end else begin
      level = LVL_0;
    end
    if (change10 < {4'b0, fs.dlen}) begin
      level = (fs.cur > LVL_4) ? LVL_4 : fs.cur;
    end
  end

  // output register
  logic        ov_q, obe_q;
  logic [2:0]  olvl_q;
  logic [31:0] odist_q, ocov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= dv[DIV_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      olvl_q  <= level;
      odist_q <= fs.dlen;
      ocov_q  <= cov;
      obe_q   <= fs.be;
    end
  end

  assign out_o.valid          = ov_q;
  assign out_o.selected_level = olvl_q;
  assign out_o.distance       = odist_q;
  assign out_o.coverage       = ocov_q;
  assign out_o.batch_end_out  = obe_q;

  `LSC_ASSERT(a_ready_follows_stall, in_i.ready == !(out_o.valid && !out_o.ready))
  `LSC_ASSERT(a_level_range, out_o.valid |-> out_o.selected_level <= LVL_4)
  `LSC_ASSERT_NR(a_reset_empty, !rst_ni |=> !out_o.valid)
endmodule
